>>> sv/rasr_pkg.sv
package rasr_pkg;

  // Operand sizing. Numerators are OPERAND_WIDTH bits, denominators one bit less.
  localparam int OPERAND_WIDTH = 16;
  localparam int DEN_IN_W      = OPERAND_WIDTH - 1;
  localparam int PROD_W        = 2 * OPERAND_WIDTH - 1;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;
  localparam int CNT_W         = $clog2(MAG_W);

  // Result field widths.
  localparam int NUM_OUT_W = 32;
  localparam int DEN_OUT_W = 30;

  // Operation selector codes.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // Status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DEN_ZERO = 1'b1;

  typedef logic [MAG_W-1:0] mag_t;

endpackage

>>> sv/rasr_in_if.sv
interface rasr_in_if;

  logic                                       valid;
  logic                                       ready;
  logic                                       operation;
  logic signed [rasr_pkg::OPERAND_WIDTH-1:0] first_num;
  logic        [rasr_pkg::DEN_IN_W-1:0]      first_den;
  logic signed [rasr_pkg::OPERAND_WIDTH-1:0] second_num;
  logic        [rasr_pkg::DEN_IN_W-1:0]      second_den;

  modport source (
    output valid, operation, first_num, first_den, second_num, second_den,
    input  ready
  );

  modport sink (
    input  valid, operation, first_num, first_den, second_num, second_den,
    output ready
  );

endinterface

>>> sv/rasr_out_if.sv
interface rasr_out_if;

  logic                                   valid;
  logic                                   ready;
  logic signed [rasr_pkg::NUM_OUT_W-1:0] result_num;
  logic        [rasr_pkg::DEN_OUT_W-1:0] result_den;
  logic                                   status;

  modport source (
    output valid, result_num, result_den, status,
    input  ready
  );

  modport sink (
    input  valid, result_num, result_den, status,
    output ready
  );

endinterface

>>> sv/rasr_mul.sv
module rasr_mul (
  input  logic                                clk,
  input  logic [rasr_pkg::OPERAND_WIDTH-1:0] a,
  input  logic [rasr_pkg::DEN_IN_W-1:0]      b,
  output logic [rasr_pkg::PROD_W-1:0]        p_r
);

  // Single registered multiplier, shared by all three products of an item.
  always_ff @(posedge clk) begin
    p_r <= rasr_pkg::PROD_W'(a) * rasr_pkg::PROD_W'(b);
  end

endmodule

>>> sv/rasr_gcd.sv
module rasr_gcd (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rasr_pkg::mag_t       a_in,
  input  rasr_pkg::mag_t       b_in,
  output logic                 busy,
  output logic                 done,
  output rasr_pkg::mag_t       g
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  rasr_pkg::mag_t              a_r, a_nxt;
  rasr_pkg::mag_t              b_r, b_nxt;
  rasr_pkg::mag_t              g_r, g_nxt;
  logic [rasr_pkg::CNT_W-1:0]  k_r, k_nxt;

  // One binary gcd step per cycle: halve even operands, subtract odd ones.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a_in;
      b_nxt    = b_in;
      k_nxt    = '0;
    end else if (busy_r) begin
      if (a_r == '0 || b_r == '0) begin
        // One operand reached zero, so the other holds the odd part of the gcd.
        g_nxt    = rasr_pkg::MAG_W'((a_r | b_r) << k_r);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign g    = g_r;

endmodule

>>> sv/rasr_div.sv
module rasr_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rasr_pkg::mag_t       dividend,
  input  rasr_pkg::mag_t       divisor,
  output logic                 busy,
  output logic                 done,
  output rasr_pkg::mag_t       quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  rasr_pkg::mag_t              rem_r, rem_nxt;
  rasr_pkg::mag_t              quo_r, quo_nxt;
  rasr_pkg::mag_t              dsr_r, dsr_nxt;
  logic [rasr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [rasr_pkg::MAG_W:0]    trial;
  logic                        fits;

  // Restoring division, one quotient bit per cycle, dividend bits shifted in MSB first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    trial    = {rem_r, quo_r[rasr_pkg::MAG_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rasr_pkg::MAG_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = rasr_pkg::MAG_W'(trial);
      end
      quo_nxt = {quo_r[rasr_pkg::MAG_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rasr_pkg::CNT_W'(rasr_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/rational_add_sub_reduce.sv
// Adds or subtracts two fractions and returns the sum reduced to lowest terms, with the
// sign carried by the numerator; a zero input denominator returns status 1 and 0/0, a
// zero sum returns 0/1. Items are handled one at a time and the input is ready only when
// the sequencer is idle. A zero-denominator item goes straight to the finish step, and a
// sum that cancels to zero finishes after the sum step. Otherwise one multiplier forms the
// three products in turn, a sum step follows, then a binary gcd loop that takes one step
// per cycle and finishes sooner for small operands, then one shared divider reduces
// numerator and denominator in turn. A finished result waits in an output register while
// the next item is taken; the last step of an item stalls while that register still holds
// a result that has not been transferred.
module rational_add_sub_reduce (
  input  logic              clk,
  input  logic              rst_n,
  rasr_in_if.sink           in_ch,
  rasr_out_if.source        out_ch
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL1    = 4'd1;
  localparam logic [3:0] S_MUL2    = 4'd2;
  localparam logic [3:0] S_MUL3    = 4'd3;
  localparam logic [3:0] S_SUM     = 4'd4;
  localparam logic [3:0] S_GCD     = 4'd5;
  localparam logic [3:0] S_DIV_NUM = 4'd6;
  localparam logic [3:0] S_DIV_DEN = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0]                          state_r, state_nxt;

  // Captured operands.
  logic                                in_op_r;
  logic                                neg1_r, neg2_r;
  logic [rasr_pkg::OPERAND_WIDTH-1:0]  mag1_r, mag2_r;
  logic [rasr_pkg::DEN_IN_W-1:0]       d1_r, d2_r;
  logic [rasr_pkg::PROD_W-1:0]         t1_r, t2_r;
  rasr_pkg::mag_t                      mag_r, den_r, num_q_r;
  logic                                neg_r;

  // Staged result and output register.
  logic signed [rasr_pkg::NUM_OUT_W-1:0] res_num_r;
  logic        [rasr_pkg::DEN_OUT_W-1:0] res_den_r;
  logic                                  res_status_r;
  logic                                  out_valid_r;
  logic signed [rasr_pkg::NUM_OUT_W-1:0] out_num_r;
  logic        [rasr_pkg::DEN_OUT_W-1:0] out_den_r;
  logic                                  out_status_r;

  // Input decode.
  logic [rasr_pkg::OPERAND_WIDTH-1:0]  raw1, raw2, in_mag1, in_mag2;
  logic                                in_xfer, out_xfer, den_zero;

  // Shared units.
  logic [rasr_pkg::OPERAND_WIDTH-1:0]  mul_a;
  logic [rasr_pkg::DEN_IN_W-1:0]       mul_b;
  logic [rasr_pkg::PROD_W-1:0]         mul_p;
  logic                                gcd_start, gcd_busy, gcd_done;
  rasr_pkg::mag_t                      gcd_a, gcd_b, gcd_g;
  logic                                div_start, div_busy, div_done;
  rasr_pkg::mag_t                      div_dividend, div_q;

  // Signed sum of the two cross products.
  logic                                eff_neg2, sum_neg;
  rasr_pkg::mag_t                      sum_mag;
  logic signed [rasr_pkg::MAG_W:0]     snum;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;
  assign raw1     = in_ch.first_num;
  assign raw2     = in_ch.second_num;
  assign in_mag1  = raw1[rasr_pkg::OPERAND_WIDTH-1] ?
                    rasr_pkg::OPERAND_WIDTH'(~raw1 + 1'b1) : raw1;
  assign in_mag2  = raw2[rasr_pkg::OPERAND_WIDTH-1] ?
                    rasr_pkg::OPERAND_WIDTH'(~raw2 + 1'b1) : raw2;
  assign den_zero = (in_ch.first_den == '0) || (in_ch.second_den == '0);

  // Multiplier operand selection by sequencer step.
  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_a = mag1_r;
        mul_b = d2_r;
      end
      S_MUL2: begin
        mul_a = mag2_r;
        mul_b = d1_r;
      end
      default: begin
        mul_a = rasr_pkg::OPERAND_WIDTH'(d1_r);
        mul_b = d2_r;
      end
    endcase
  end

  rasr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Sign-magnitude addition of the cross products.
  always_comb begin
    eff_neg2 = neg2_r;
    if (in_op_r == rasr_pkg::OP_SUB) begin
      eff_neg2 = !neg2_r;
    end
    if (neg1_r == eff_neg2) begin
      sum_mag = rasr_pkg::MAG_W'(t1_r) + rasr_pkg::MAG_W'(t2_r);
      sum_neg = neg1_r;
    end else if (t1_r >= t2_r) begin
      sum_mag = rasr_pkg::MAG_W'(t1_r - t2_r);
      sum_neg = neg1_r;
    end else begin
      sum_mag = rasr_pkg::MAG_W'(t2_r - t1_r);
      sum_neg = eff_neg2;
    end
  end

  assign gcd_start = (state_r == S_SUM) && (sum_mag != '0);
  assign gcd_a     = sum_mag;
  assign gcd_b     = rasr_pkg::MAG_W'(mul_p);

  rasr_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (gcd_a),
    .b_in  (gcd_b),
    .busy  (gcd_busy),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  // The divider runs twice: first the numerator, then the denominator.
  assign div_start    = ((state_r == S_GCD) && gcd_done) ||
                        ((state_r == S_DIV_NUM) && div_done);
  assign div_dividend = (state_r == S_GCD) ? mag_r : den_r;

  rasr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Reapply the sign to the reduced numerator.
  always_comb begin
    snum = $signed({1'b0, num_q_r});
    if (neg_r) begin
      snum = -snum;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = den_zero ? S_FINISH : S_MUL1;
        end
      end
      S_MUL1:    state_nxt = S_MUL2;
      S_MUL2:    state_nxt = S_MUL3;
      S_MUL3:    state_nxt = S_SUM;
      S_SUM:     state_nxt = (sum_mag == '0) ? S_FINISH : S_GCD;
      S_GCD: begin
        if (gcd_done) begin
          state_nxt = S_DIV_NUM;
        end
      end
      S_DIV_NUM: begin
        if (div_done) begin
          state_nxt = S_DIV_DEN;
        end
      end
      S_DIV_DEN: begin
        if (div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FINISH && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_op_r      <= in_ch.operation;
      neg1_r       <= raw1[rasr_pkg::OPERAND_WIDTH-1];
      neg2_r       <= raw2[rasr_pkg::OPERAND_WIDTH-1];
      mag1_r       <= in_mag1;
      mag2_r       <= in_mag2;
      d1_r         <= in_ch.first_den;
      d2_r         <= in_ch.second_den;
      res_num_r    <= '0;
      res_den_r    <= '0;
      res_status_r <= rasr_pkg::STATUS_DEN_ZERO;
    end
    if (state_r == S_MUL2) begin
      t1_r <= mul_p;
    end
    if (state_r == S_MUL3) begin
      t2_r <= mul_p;
    end
    if (state_r == S_SUM) begin
      den_r <= rasr_pkg::MAG_W'(mul_p);
      mag_r <= sum_mag;
      neg_r <= sum_neg;
      if (sum_mag == '0) begin
        res_num_r    <= '0;
        res_den_r    <= rasr_pkg::DEN_OUT_W'(1);
        res_status_r <= rasr_pkg::STATUS_OK;
      end
    end
    if (state_r == S_DIV_NUM && div_done) begin
      num_q_r <= div_q;
    end
    if (state_r == S_DIV_DEN && div_done) begin
      res_num_r    <= rasr_pkg::NUM_OUT_W'(snum);
      res_den_r    <= rasr_pkg::DEN_OUT_W'(div_q);
      res_status_r <= rasr_pkg::STATUS_OK;
    end
    if (state_r == S_FINISH && (!out_valid_r || out_ch.ready)) begin
      out_num_r    <= res_num_r;
      out_den_r    <= res_den_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_num = out_num_r;
  assign out_ch.result_den = out_den_r;
  assign out_ch.status     = out_status_r;

  // An error result always carries a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == rasr_pkg::STATUS_DEN_ZERO |->
      out_num_r == '0 && out_den_r == '0)
    else $error("error result carries a nonzero fraction");

  // A good result never has a zero denominator.
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == rasr_pkg::STATUS_OK |-> out_den_r != '0)
    else $error("good result with zero denominator");

  // The gcd handed to the divider is never zero.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_done |-> gcd_g != '0)
    else $error("gcd finished with zero");

  // The gcd unit is only started while it is idle.
  a_gcd_free: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_start |-> !gcd_busy)
    else $error("gcd started while busy");

  // The divider is only restarted once it has finished.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A transfer in closes the input until the item is finished.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input reopened right after a transfer");

endmodule

>>> test/rational_add_sub_reduce_test.sv
`timescale 1ns / 1ps

module rational_add_sub_reduce_test;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_OFF_CYCLES = 1000;
  localparam int DRAIN_CYCLES = 250;

  // One input transfer: two fractions and the add/subtract selector.
  typedef struct {
    logic                                      operation;
    logic signed [rasr_pkg::OPERAND_WIDTH-1:0] first_num;
    logic        [rasr_pkg::DEN_IN_W-1:0]      first_den;
    logic signed [rasr_pkg::OPERAND_WIDTH-1:0] second_num;
    logic        [rasr_pkg::DEN_IN_W-1:0]      second_den;
  } operands_t;

  // One result transfer: the reduced fraction and its status.
  typedef struct {
    logic signed [rasr_pkg::NUM_OUT_W-1:0] num;
    logic        [rasr_pkg::DEN_OUT_W-1:0] den;
    logic                                  status;
  } fraction_t;

  // Keeps the reduced fractions still owed by the block, in arrival order.
  class fraction_scoreboard;
    fraction_t pending_sums[$];
    int        errors;
    int        checked;
    int        den_zero_count;
    int        zero_sum_count;

    function new();
      errors = 0;
      checked = 0;
      den_zero_count = 0;
      zero_sum_count = 0;
    endfunction

    // Cross-multiplies, then divides numerator and denominator by their gcd.
    function fraction_t reduce_sum(operands_t op);
      fraction_t r;
      longint    cross_a, cross_b, sum, den, mag, x, y, rem;
      r.status = rasr_pkg::STATUS_OK;
      if (op.first_den == '0 || op.second_den == '0) begin
        r.num = '0;
        r.den = '0;
        r.status = rasr_pkg::STATUS_DEN_ZERO;
        return r;
      end
      cross_a = longint'(op.first_num) * longint'(op.second_den);
      cross_b = longint'(op.second_num) * longint'(op.first_den);
      sum = (op.operation == rasr_pkg::OP_SUB) ? cross_a - cross_b : cross_a + cross_b;
      den = longint'(op.first_den) * longint'(op.second_den);
      if (sum == 0) begin
        r.num = '0;
        r.den = rasr_pkg::DEN_OUT_W'(1);
        return r;
      end
      mag = (sum < 0) ? -sum : sum;
      x = mag;
      y = den;
      while (y != 0) begin
        rem = x % y;
        x = y;
        y = rem;
      end
      mag = mag / x;
      den = den / x;
      sum = (sum < 0) ? -mag : mag;
      r.num = sum[rasr_pkg::NUM_OUT_W-1:0];
      r.den = den[rasr_pkg::DEN_OUT_W-1:0];
      return r;
    endfunction

    function void note_operands(operands_t op);
      fraction_t want;
      want = reduce_sum(op);
      if (want.status == rasr_pkg::STATUS_DEN_ZERO) den_zero_count++;
      else if (want.num == '0) zero_sum_count++;
      pending_sums.push_back(want);
    endfunction

    function void check_fraction(logic signed [rasr_pkg::NUM_OUT_W-1:0] num,
                                 logic [rasr_pkg::DEN_OUT_W-1:0] den, logic status);
      fraction_t want;
      if (pending_sums.size() == 0) begin
        $error("unexpected result %0d/%0d status %0b with nothing pending", num, den, status);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      checked++;
      if (num !== want.num) begin
        $error("result_num: expected %0d, got %0d", want.num, num);
        errors++;
      end
      if (den !== want.den) begin
        $error("result_den: expected %0d, got %0d", want.den, den);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0b, got %0b", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   items_sent;

  rasr_in_if  in_ch ();
  rasr_out_if out_ch ();

  fraction_scoreboard sb;

  rational_add_sub_reduce uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net in case the block hangs.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic operands_t make_operands(logic op, int n1, int d1, int n2, int d2);
    operands_t r;
    r.operation = op;
    r.first_num = n1[rasr_pkg::OPERAND_WIDTH-1:0];
    r.first_den = d1[rasr_pkg::DEN_IN_W-1:0];
    r.second_num = n2[rasr_pkg::OPERAND_WIDTH-1:0];
    r.second_den = d2[rasr_pkg::DEN_IN_W-1:0];
    return r;
  endfunction

  // Mix of full-range operands, small operands that reduce well,
  // sums that cancel to zero and zero denominators.
  function automatic operands_t random_operands();
    operands_t r;
    int        kind, scale, n1, d1;
    kind = $urandom_range(0, 9);
    r.operation = $urandom_range(0, 1) ? rasr_pkg::OP_SUB : rasr_pkg::OP_ADD;
    r.first_num = rasr_pkg::OPERAND_WIDTH'($urandom);
    r.second_num = rasr_pkg::OPERAND_WIDTH'($urandom);
    r.first_den = rasr_pkg::DEN_IN_W'($urandom_range(1, 32767));
    r.second_den = rasr_pkg::DEN_IN_W'($urandom_range(1, 32767));
    case (kind)
      0: begin
        case ($urandom_range(0, 2))
          0: r.first_den = '0;
          1: r.second_den = '0;
          default: begin
            r.first_den = '0;
            r.second_den = '0;
          end
        endcase
      end
      1, 2, 3: begin
        r = make_operands(r.operation, $urandom_range(0, 40) - 20, $urandom_range(1, 24),
                          $urandom_range(0, 40) - 20, $urandom_range(1, 24));
      end
      4: begin
        // Equal fractions in different terms, arranged to cancel.
        n1 = $urandom_range(0, 400) - 200;
        d1 = $urandom_range(1, 500);
        scale = $urandom_range(1, 50);
        r = make_operands(r.operation, n1, d1,
                          (r.operation == rasr_pkg::OP_SUB) ? n1 * scale : -n1 * scale,
                          d1 * scale);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one item and waits for its transfer.
  task automatic send_operands(input operands_t op);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op.operation;
    in_ch.first_num <= op.first_num;
    in_ch.first_den <= op.first_den;
    in_ch.second_num <= op.second_num;
    in_ch.second_den <= op.second_den;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operands(op);
    items_sent++;
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Result side: checks every transfer and stalls on its own pattern,
  // with one long hold-off that backs the block up into its input.
  initial begin
    int  mode, mode_left, phase, hold_left;
    bit  hold_done, take;
    mode = 0;
    mode_left = 0;
    phase = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready)
        sb.check_fraction(out_ch.result_num, out_ch.result_den, out_ch.status);
      if (!hold_done && sb.checked >= 120) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 200);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (mode)
          0: take = 1'b1;
          1: take = $urandom_range(0, 1);
          2: take = (phase % 4) == 0;
          default: take = $urandom_range(0, 7) == 0;
        endcase
      end
      out_ch.ready <= take;
      @(posedge clk);
    end
  end

  // Input side: reset, directed cases, then random bursts.
  initial begin
    int random_left, burst, gap;
    sb = new();
    items_sent = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= rasr_pkg::OP_ADD;
    in_ch.first_num <= '0;
    in_ch.first_den <= '0;
    in_ch.second_num <= '0;
    in_ch.second_den <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed cases: plain sums, cancellation to zero, zero denominators,
    // sign handling and the extremes of every field.
    send_operands(make_operands(rasr_pkg::OP_ADD, 1, 2, 1, 3));
    send_operands(make_operands(rasr_pkg::OP_SUB, 1, 2, 1, 2));
    send_operands(make_operands(rasr_pkg::OP_ADD, 0, 5, 0, 7));
    send_operands(make_operands(rasr_pkg::OP_ADD, 3, 0, 4, 5));
    send_operands(make_operands(rasr_pkg::OP_SUB, 3, 5, 4, 0));
    send_operands(make_operands(rasr_pkg::OP_ADD, -32768, 0, 32767, 0));
    send_operands(make_operands(rasr_pkg::OP_SUB, -32768, 1, 32767, 1));
    send_operands(make_operands(rasr_pkg::OP_ADD, -32768, 32767, -32768, 32767));
    send_operands(make_operands(rasr_pkg::OP_ADD, 32767, 32767, 32767, 32767));
    send_operands(make_operands(rasr_pkg::OP_SUB, -32768, 1, -32768, 1));
    send_operands(make_operands(rasr_pkg::OP_SUB, 32767, 1, -32768, 32767));
    send_operands(make_operands(rasr_pkg::OP_SUB, -32768, 32767, 32767, 1));
    send_operands(make_operands(rasr_pkg::OP_SUB, 1, 32767, 1, 32766));
    send_operands(make_operands(rasr_pkg::OP_ADD, -3, 4, 1, 4));
    send_operands(make_operands(rasr_pkg::OP_SUB, 6, 4, 9, 2));
    send_operands(make_operands(rasr_pkg::OP_SUB, 0, 1, 32767, 32767));
    send_operands(make_operands(rasr_pkg::OP_ADD, -1, 1, -1, 1));
    send_operands(make_operands(rasr_pkg::OP_ADD, 21845, 21845, -10922, 10922));
    send_operands(make_operands(rasr_pkg::OP_SUB, 12, 18, -10, 15));
    send_operands(make_operands(rasr_pkg::OP_ADD, -32768, 16384, 0, 32767));

    // Random bursts separated by random gaps, now and then a long run.
    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      while (burst > 0 && random_left > 0) begin
        send_operands(random_operands());
        burst--;
        random_left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      pause_input(gap);
    end
    in_ch.valid <= 1'b0;

    // Drain, then leave room for any stray result.
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d fraction pairs, checked %0d reduced results.", items_sent, sb.checked);
    $display("Zero-denominator errors: %0d, sums cancelling to zero: %0d.",
             sb.den_zero_count, sb.zero_sum_count);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
